// ----- rtl/core/pqs_pkg.sv -----
// Shared word types, codes and limits for the priority quantum scheduler.
package pqs_pkg;

  localparam int unsigned TIME_W = 24;
  localparam int unsigned SUM_W  = 29;

  // action codes
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STEP   = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_LOADED = 3'd0;
  localparam logic [2:0] KIND_IDLE   = 3'd1;
  localparam logic [2:0] KIND_SLICE  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_REPORT = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
    logic [7:0]  task_priority;
    logic [3:0]  entry_index;
  } item_word_t;

  typedef struct packed {
    logic [2:0]        result_kind;
    logic [4:0]        task_number;
    logic [TIME_W-1:0] time_now;
    logic [15:0]       slice_length;
    logic              finished_now;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
  } result_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic       scan_start;
    logic       scan_issue;
    logic       rpt_rd;
    logic       rpt_data;
    logic       idle_tick;
    logic       exec;
    logic       tat;
    logic       wt;
    logic       accum;
    logic       out_load;
    logic [2:0] out_kind;
  } pqs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       all_done;
    logic       rpt_ok;
    logic       scan_last;
    logic       found;
    logic       out_free;
  } pqs_stat_t;

endpackage

// ----- rtl/core/pqs_ctrl.sv -----
// Sequencing state machine of the priority quantum scheduler.
module pqs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pqs_pkg::pqs_stat_t stat,
  output pqs_pkg::pqs_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_SCAN     = 11'b000_0000_0100,
    S_SCAN_END = 11'b000_0000_1000,
    S_DECIDE   = 11'b000_0001_0000,
    S_EXEC     = 11'b000_0010_0000,
    S_RPT_DATA = 11'b000_0100_0000,
    S_TAT      = 11'b000_1000_0000,
    S_WT       = 11'b001_0000_0000,
    S_ACCUM    = 11'b010_0000_0000,
    S_RESULT   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [2:0] kind, kind_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    cmd          = '0;
    cmd.out_kind = kind;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.action)
          pqs_pkg::ACT_LOAD: begin
            state_next = S_RESULT;
            if (stat.full) begin
              kind_next = pqs_pkg::KIND_ERROR;
            end else begin
              kind_next   = pqs_pkg::KIND_LOADED;
              cmd.load_wr = 1'b1;
            end
          end
          pqs_pkg::ACT_STEP: begin
            if (stat.all_done) begin
              kind_next  = pqs_pkg::KIND_DONE;
              state_next = S_RESULT;
            end else begin
              kind_next      = pqs_pkg::KIND_SLICE;
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          pqs_pkg::ACT_REPORT: begin
            if (stat.rpt_ok) begin
              kind_next  = pqs_pkg::KIND_REPORT;
              cmd.rpt_rd = 1'b1;
              state_next = S_RPT_DATA;
            end else begin
              kind_next  = pqs_pkg::KIND_ERROR;
              state_next = S_RESULT;
            end
          end
          default: begin
            kind_next  = pqs_pkg::KIND_ERROR;
            state_next = S_RESULT;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_DECIDE;
      S_DECIDE: begin
        if (stat.found) begin
          state_next = S_EXEC;
        end else begin
          cmd.idle_tick = 1'b1;
          kind_next     = pqs_pkg::KIND_IDLE;
          state_next    = S_RESULT;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_TAT;
      end
      S_RPT_DATA: begin
        cmd.rpt_data = 1'b1;
        state_next   = S_TAT;
      end
      S_TAT: begin
        cmd.tat    = 1'b1;
        state_next = S_WT;
      end
      S_WT: begin
        cmd.wt     = 1'b1;
        state_next = (kind == pqs_pkg::KIND_SLICE) ? S_ACCUM : S_RESULT;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= pqs_pkg::KIND_ERROR;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

// ----- rtl/core/pqs_dp.sv -----
// Task table, scan compare, time arithmetic and result register.
module pqs_dp #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pqs_pkg::item_word_t   item_word,
  input  logic                  cfg_valid,
  input  logic [15:0]           cfg_data,
  input  pqs_pkg::pqs_cmd_t     cmd,
  output pqs_pkg::pqs_stat_t    stat,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pqs_pkg::result_word_t result_word
);

  localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW    = pqs_pkg::TIME_W;
  localparam int unsigned SW    = pqs_pkg::SUM_W;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
  } info_t;

  // table memories, one shared read address
  info_t       info_mem [MAX_PROCS];
  logic [15:0] rem_mem  [MAX_PROCS];
  logic [TW-1:0] comp_mem [MAX_PROCS];
  info_t       rd_info;
  logic [15:0] rd_rem;
  logic [TW-1:0] rd_comp;

  logic [MAX_PROCS-1:0] done;
  logic [CNT_W-1:0]     task_cnt, fin_cnt;
  logic [TW-1:0]        clock_q;
  logic [SW-1:0]        wait_sum, tat_sum;
  logic [15:0]          quantum;
  pqs_pkg::item_word_t  item_q;

  // scan state
  logic [IDX_W-1:0] scan_idx, cmp_idx, best_idx;
  logic             cmp_v, found;
  logic [15:0]      best_arr, best_burst, best_rem;
  logic [7:0]       best_pri;

  // per-item working registers
  logic [4:0]    num_q;
  logic [15:0]   slice_q;
  logic          fin_q;
  logic [TW-1:0] op_comp, tat_q, wt_q;
  logic [15:0]   op_arr, op_burst;

  logic [IDX_W-1:0] rd_addr, ent_addr, load_addr;
  logic             elig, better;
  logic [15:0]      q_eff, slice, rem_new;
  logic [TW:0]      clk_sum;
  logic [TW-1:0]    clock_next, tat_calc, wt_calc;
  logic [SW:0]      wsum_add, tsum_add;
  logic             free;

  assign ent_addr  = IDX_W'(item_q.entry_index);
  assign load_addr = IDX_W'(task_cnt);
  assign rd_addr   = cmd.rpt_rd ? ent_addr : scan_idx;

  assign stat.action    = item_q.action;
  assign stat.full      = (task_cnt == CNT_W'(MAX_PROCS));
  assign stat.all_done  = (fin_cnt >= task_cnt);
  assign stat.rpt_ok    = (32'(item_q.entry_index) < 32'(task_cnt));
  assign stat.scan_last = (scan_idx == IDX_W'(task_cnt - CNT_W'(1)));
  assign stat.found     = found;
  assign free           = !result_valid || result_ready;
  assign stat.out_free  = free;

  // eligibility and priority order
  assign elig   = cmp_v && !done[cmp_idx] && (TW'(rd_info.arrival) <= clock_q);
  assign better = !found || (rd_info.prio < best_pri) ||
                  ((rd_info.prio == best_pri) && (rd_info.arrival < best_arr));

  // slice and saturating clock
  assign q_eff      = (quantum == 16'd0) ? 16'd1 : quantum;
  assign slice      = (best_rem < q_eff) ? best_rem : q_eff;
  assign rem_new    = best_rem - slice;
  assign clk_sum    = {1'b0, clock_q} + (TW + 1)'(cmd.exec ? slice : 16'd1);
  assign clock_next = clk_sum[TW] ? '1 : clk_sum[TW-1:0];

  assign tat_calc = (op_comp >= TW'(op_arr)) ? (op_comp - TW'(op_arr)) : '0;
  assign wt_calc  = (tat_q >= TW'(op_burst)) ? (tat_q - TW'(op_burst)) : '0;
  assign wsum_add = {1'b0, wait_sum} + (SW + 1)'(wt_q);
  assign tsum_add = {1'b0, tat_sum} + (SW + 1)'(tat_q);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      info_mem[load_addr] <= '{arrival: item_q.arrival_time,
                               burst:   item_q.burst_length,
                               prio:    item_q.task_priority};
    end
    if (cmd.load_wr) begin
      rem_mem[load_addr] <= item_q.burst_length;
    end else if (cmd.exec) begin
      rem_mem[best_idx] <= rem_new;
    end
    if (cmd.exec) comp_mem[best_idx] <= clock_next;
    rd_info <= info_mem[rd_addr];
    rd_rem  <= rem_mem[rd_addr];
    rd_comp <= comp_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= '0;
      task_cnt     <= '0;
      fin_cnt      <= '0;
      clock_q      <= '0;
      wait_sum     <= '0;
      tat_sum      <= '0;
      quantum      <= 16'd1;
      cmp_v        <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) quantum <= cfg_data;
      cmp_v <= cmd.scan_issue;
      if (cmd.load_wr) begin
        done[load_addr] <= 1'b0;
        task_cnt        <= task_cnt + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (elig && better) begin
        found <= 1'b1;
      end
      if (cmd.idle_tick || cmd.exec) clock_q <= clock_next;
      if (cmd.exec && (rem_new == 16'd0)) begin
        done[best_idx] <= 1'b1;
        fin_cnt        <= fin_cnt + CNT_W'(1);
      end
      if (cmd.accum && fin_q) begin
        wait_sum <= wsum_add[SW] ? '1 : wsum_add[SW-1:0];
        tat_sum  <= tsum_add[SW] ? '1 : tsum_add[SW-1:0];
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) item_q <= item_word;
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    cmp_idx <= scan_idx;
    if (elig && better) begin
      best_idx   <= cmp_idx;
      best_arr   <= rd_info.arrival;
      best_burst <= rd_info.burst;
      best_pri   <= rd_info.prio;
      best_rem   <= rd_rem;
    end
    if (cmd.load_wr) num_q <= 5'(32'(task_cnt) + 32'd1);
    if (cmd.rpt_rd) begin
      num_q <= 5'(32'(item_q.entry_index) + 32'd1);
      fin_q <= done[ent_addr];
    end
    if (cmd.exec) begin
      num_q    <= 5'(32'(best_idx) + 32'd1);
      slice_q  <= slice;
      fin_q    <= (rem_new == 16'd0);
      op_comp  <= clock_next;
      op_arr   <= best_arr;
      op_burst <= best_burst;
    end
    if (cmd.rpt_data) begin
      op_comp  <= rd_comp;
      op_arr   <= rd_info.arrival;
      op_burst <= rd_info.burst;
    end
    if (cmd.tat) tat_q <= tat_calc;
    if (cmd.wt)  wt_q  <= wt_calc;
    if (cmd.out_load) begin
      result_word.result_kind <= cmd.out_kind;
      result_word.task_number <=
        ((cmd.out_kind == pqs_pkg::KIND_LOADED) || (cmd.out_kind == pqs_pkg::KIND_SLICE) ||
         (cmd.out_kind == pqs_pkg::KIND_REPORT)) ? num_q : 5'd0;
      result_word.time_now     <= clock_q;
      result_word.slice_length <= (cmd.out_kind == pqs_pkg::KIND_SLICE) ? slice_q : 16'd0;
      if (((cmd.out_kind == pqs_pkg::KIND_SLICE) || (cmd.out_kind == pqs_pkg::KIND_REPORT))
          && fin_q) begin
        result_word.finished_now    <= 1'b1;
        result_word.completion_time <= op_comp;
        result_word.turnaround_time <= tat_q;
        result_word.waiting_time    <= wt_q;
      end else begin
        result_word.finished_now    <= 1'b0;
        result_word.completion_time <= '0;
        result_word.turnaround_time <= '0;
        result_word.waiting_time    <= '0;
      end
      result_word.total_waiting    <= wait_sum;
      result_word.total_turnaround <= tat_sum;
    end
  end

  a_fin_le_tasks: assert property (@(posedge clk) disable iff (rst)
    fin_cnt <= task_cnt)
    else $error("finished count above task count");

  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> clock_q >= $past(clock_q))
    else $error("clock went backwards");

  a_zero_slice_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (slice_q != 16'd0) || fin_q)
    else $error("empty slice on an unfinished task");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> free)
    else $error("result word overwritten before taken");

endmodule

// ----- rtl/core/priority_quantum_scheduler.sv -----
// Top level of the priority quantum scheduler: controller plus datapath.
//
// Keeps a table of up to MAX_PROCS tasks and handles one word at a time:
// a load appends a task, a step makes one scheduling decision (the most
// urgent arrived, unfinished task runs for min(remaining, quantum); ties go
// to earlier arrival, then lower index; nothing arrived ticks the clock by
// one), a report reads back one row. Every input word yields exactly one
// result word. A step scans the table, which reads one entry per cycle
// through the single read port of the task memories. A new word is taken
// once the previous result is registered, even if that result has not yet
// been taken downstream. The quantum register is written through cfg at any
// time the block is idle; cfg_ready is always high and a quantum of zero
// behaves as one. Times saturate at 2^24-1 and totals at 2^29-1.
module priority_quantum_scheduler #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  pqs_pkg::item_word_t   item_word,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pqs_pkg::result_word_t result_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);

  pqs_pkg::pqs_cmd_t  cmd;
  pqs_pkg::pqs_stat_t stat;

  // quantum register always writable
  assign cfg_ready = 1'b1;

  pqs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pqs_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_word    (item_word),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule

// ----- tb/priority_quantum_scheduler_tb.sv -----
// Self-checking testbench for the priority quantum scheduler: directed table, then random phases.
module priority_quantum_scheduler_tb;

  localparam int unsigned MAX_TASKS   = 16;
  localparam int unsigned PHASE_WORDS = 130;
  localparam int unsigned NUM_PHASES  = 4;
  localparam int unsigned SETTLE_CYC  = 40;
  localparam logic [1:0]  ACT_UNKNOWN = 2'd3;
  localparam logic [31:0] CLOCK_LIMIT = 32'h00FF_FFFF;
  localparam logic [31:0] TOTAL_LIMIT = 32'h1FFF_FFFF;

  typedef struct {
    pqs_pkg::item_word_t   word;
    bit                    typed;
    pqs_pkg::result_word_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  pqs_pkg::item_word_t   item_word = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  pqs_pkg::result_word_t result_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [15:0]           cfg_data = '0;

  // shadow copy of the task table and counters
  logic [15:0]  arr_tab  [MAX_TASKS];
  logic [15:0]  burst_tab[MAX_TASKS];
  logic [7:0]   prio_tab [MAX_TASKS];
  logic [15:0]  left_tab [MAX_TASKS];
  bit           done_tab [MAX_TASKS];
  logic [23:0]  comp_tab [MAX_TASKS];
  int unsigned  n_tasks    = 0;
  int unsigned  n_finished = 0;
  logic [23:0]  clk_pred   = '0;
  logic [28:0]  wait_total = '0;
  logic [28:0]  tat_total  = '0;
  logic [15:0]  quantum_q  = 16'd1;

  pqs_pkg::result_word_t pending_results[$];
  pqs_pkg::result_word_t oldest_result;
  int unsigned           mismatch_count = 0;
  bit                    steady_run = 1'b0;

  priority_quantum_scheduler #(
    .MAX_PROCS(MAX_TASKS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item_word   (item_word),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word (result_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b, logic [31:0] limit);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > limit) ? limit : s[31:0];
  endfunction

  // saturation can leave turnaround short of burst
  function automatic logic [23:0] turnaround_of(int unsigned k);
    return (comp_tab[k] >= arr_tab[k]) ? comp_tab[k] - arr_tab[k] : '0;
  endfunction

  function automatic logic [23:0] waiting_of(int unsigned k);
    logic [23:0] t;
    t = turnaround_of(k);
    return (t >= burst_tab[k]) ? t - burst_tab[k] : '0;
  endfunction

  // advances the shadow table by one word and returns the result it should give
  function automatic pqs_pkg::result_word_t schedule_word(pqs_pkg::item_word_t w);
    pqs_pkg::result_word_t r;
    int unsigned  k;
    int unsigned  pick;
    bit           found;
    logic [7:0]   best;
    logic [15:0]  q;
    logic [15:0]  run;
    r = '0;
    r.result_kind = pqs_pkg::KIND_ERROR;
    case (w.action)
      pqs_pkg::ACT_LOAD: begin
        if (n_tasks < MAX_TASKS) begin
          arr_tab[n_tasks]   = w.arrival_time;
          burst_tab[n_tasks] = w.burst_length;
          prio_tab[n_tasks]  = w.task_priority;
          left_tab[n_tasks]  = w.burst_length;
          done_tab[n_tasks]  = 1'b0;
          comp_tab[n_tasks]  = '0;
          n_tasks++;
          r.result_kind = pqs_pkg::KIND_LOADED;
          r.task_number = 5'(n_tasks);
        end
      end
      pqs_pkg::ACT_STEP: begin
        if (n_finished >= n_tasks) begin
          r.result_kind = pqs_pkg::KIND_DONE;
        end else begin
          found = 1'b0;
          pick  = 0;
          best  = '0;
          for (k = 0; k < n_tasks; k++) begin
            if (!done_tab[k] && arr_tab[k] <= clk_pred) begin
              if (!found || prio_tab[k] < best) begin
                best  = prio_tab[k];
                pick  = k;
                found = 1'b1;
              end else if (prio_tab[k] == best && arr_tab[k] < arr_tab[pick]) begin
                pick = k;
              end
            end
          end
          if (!found) begin
            clk_pred = 24'(sat_sum(32'(clk_pred), 32'd1, CLOCK_LIMIT));
            r.result_kind = pqs_pkg::KIND_IDLE;
          end else begin
            q   = (quantum_q == '0) ? 16'd1 : quantum_q;
            run = (left_tab[pick] < q) ? left_tab[pick] : q;
            clk_pred = 24'(sat_sum(32'(clk_pred), 32'(run), CLOCK_LIMIT));
            left_tab[pick] -= run;
            r.result_kind  = pqs_pkg::KIND_SLICE;
            r.task_number  = 5'(pick + 1);
            r.slice_length = run;
            if (left_tab[pick] == '0) begin
              comp_tab[pick] = clk_pred;
              done_tab[pick] = 1'b1;
              n_finished++;
              r.finished_now    = 1'b1;
              r.completion_time = clk_pred;
              r.turnaround_time = turnaround_of(pick);
              r.waiting_time    = waiting_of(pick);
              wait_total = 29'(sat_sum(32'(wait_total), 32'(r.waiting_time), TOTAL_LIMIT));
              tat_total  = 29'(sat_sum(32'(tat_total), 32'(r.turnaround_time), TOTAL_LIMIT));
            end
          end
        end
      end
      pqs_pkg::ACT_REPORT: begin
        k = w.entry_index;
        if (k < n_tasks) begin
          r.result_kind = pqs_pkg::KIND_REPORT;
          r.task_number = 5'(k + 1);
          if (done_tab[k]) begin
            r.finished_now    = 1'b1;
            r.completion_time = comp_tab[k];
            r.turnaround_time = turnaround_of(k);
            r.waiting_time    = waiting_of(k);
          end
        end
      end
      default: ;
    endcase
    r.time_now         = clk_pred;
    r.total_waiting    = wait_total;
    r.total_turnaround = tat_total;
    return r;
  endfunction

  function automatic pqs_pkg::item_word_t mk_item(logic [1:0] act, logic [15:0] arr,
                                                  logic [15:0] burst, logic [7:0] prio,
                                                  logic [3:0] idx);
    pqs_pkg::item_word_t w;
    w.action        = act;
    w.arrival_time  = arr;
    w.burst_length  = burst;
    w.task_priority = prio;
    w.entry_index   = idx;
    return w;
  endfunction

  // typed expectations only occur while both totals are still zero
  function automatic pqs_pkg::result_word_t plain_result(logic [2:0] kind, logic [4:0] num,
                                                         logic [23:0] tnow, logic [15:0] run,
                                                         logic fin, logic [23:0] comp,
                                                         logic [23:0] tat, logic [23:0] wt);
    pqs_pkg::result_word_t r;
    r = '0;
    r.result_kind     = kind;
    r.task_number     = num;
    r.time_now        = tnow;
    r.slice_length    = run;
    r.finished_now    = fin;
    r.completion_time = comp;
    r.turnaround_time = tat;
    r.waiting_time    = wt;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < 100) $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want_v);
    if (got !== want_v)
      flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want_v));
  endtask

  // presents one word, optionally after a gap; valid stays high into the next word
  task automatic send_word(pqs_pkg::item_word_t w, bit typed, pqs_pkg::result_word_t want);
    int unsigned           gap;
    pqs_pkg::result_word_t predicted;
    if (!steady_run && $urandom_range(0, 99) < 12) begin
      gap = $urandom_range(1, 30);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_word  <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = schedule_word(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_quantum(logic [15:0] q);
    cfg_data  <= q;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    quantum_q = q;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else     result_ready <= steady_run || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("result_kind", 32'(result_word.result_kind), 32'(oldest_result.result_kind));
        check_field("task_number", 32'(result_word.task_number), 32'(oldest_result.task_number));
        check_field("time_now", 32'(result_word.time_now), 32'(oldest_result.time_now));
        check_field("slice_length", 32'(result_word.slice_length),
                    32'(oldest_result.slice_length));
        check_field("finished_now", 32'(result_word.finished_now),
                    32'(oldest_result.finished_now));
        check_field("completion_time", 32'(result_word.completion_time),
                    32'(oldest_result.completion_time));
        check_field("turnaround_time", 32'(result_word.turnaround_time),
                    32'(oldest_result.turnaround_time));
        check_field("waiting_time", 32'(result_word.waiting_time),
                    32'(oldest_result.waiting_time));
        check_field("total_waiting", 32'(result_word.total_waiting),
                    32'(oldest_result.total_waiting));
        check_field("total_turnaround", 32'(result_word.total_turnaround),
                    32'(oldest_result.total_turnaround));
      end
    end
  end

  initial begin
    plan_row_t           plan[$];
    pqs_pkg::item_word_t w;
    int unsigned         ph;
    int unsigned         i;
    int unsigned         pick;
    logic [15:0]         phase_quantum;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, quantum at its reset value of one
    // empty table: step says all done, reports and unknown actions are errors
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(ACT_UNKNOWN, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF), 1'b1,
                     plain_result(pqs_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 4'hF), 1'b1,
                     plain_result(pqs_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0)});
    // zero burst finishes at once with an empty slice
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_LOADED, 1, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_SLICE, 1, 0, 0, 1, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_REPORT, 1, 0, 0, 1, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 0)});
    // far-off task: nothing arrived, so the clock ticks; it runs in the last phase
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_LOADED, 2, 0, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_IDLE, 0, 1, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 1), 1'b1,
                     plain_result(pqs_pkg::KIND_REPORT, 2, 1, 0, 0, 0, 0, 0)});
    // priority ties: same arrival keeps the lower index, earlier arrival wins otherwise
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 0, 2, 200, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_LOADED, 3, 1, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 0, 2, 200, 0), 1'b1,
                     plain_result(pqs_pkg::KIND_LOADED, 4, 1, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 1, 1, 200, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_LOAD, 0, 1, 200, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_STEP, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 5), 1'b0, '0});
    // index equal to the task count is out of range
    plan.push_back('{mk_item(pqs_pkg::ACT_REPORT, 0, 0, 0, 6), 1'b0, '0});

    foreach (plan[r]) send_word(plan[r].word, plan[r].typed, plan[r].want);
    drain_results();

    // random phases; the quantum changes only with the table quiet
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      steady_run = (ph == 1);
      case (ph)
        0:       phase_quantum = 16'd0;
        1:       phase_quantum = 16'd3;
        2:       phase_quantum = 16'($urandom_range(2, 8));
        default: phase_quantum = 16'hFFFF;
      endcase
      write_quantum(phase_quantum);
      for (i = 0; i < PHASE_WORDS; i++) begin
        w.arrival_time  = 16'($urandom);
        w.burst_length  = 16'($urandom);
        w.task_priority = 8'($urandom);
        w.entry_index   = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (ph == NUM_PHASES - 1 && i == 0) begin
          // long urgent job: one full-quantum slice pushes the clock past the far task
          w.action        = pqs_pkg::ACT_LOAD;
          w.arrival_time  = clk_pred[15:0];
          w.burst_length  = 16'hFFFF;
          w.task_priority = 8'd0;
        end else if (i % 43 == 5) begin
          // spaced loads keep work in the table; in the last phase they hit a full table
          w.action        = pqs_pkg::ACT_LOAD;
          w.arrival_time  = clk_pred[15:0] + 16'($urandom_range(0, 12));
          w.burst_length  = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 15));
          w.task_priority = ($urandom_range(0, 3) == 0) ? 8'd50 : 8'($urandom_range(0, 255));
        end else if (pick < 4) begin
          w.action = ACT_UNKNOWN;
        end else if (pick < 26) begin
          w.action = pqs_pkg::ACT_REPORT;
          if (n_tasks != 0 && pick < 20) w.entry_index = 4'($urandom_range(0, n_tasks - 1));
        end else begin
          w.action = pqs_pkg::ACT_STEP;
        end
        send_word(w, 1'b0, '0);
      end
      drain_results();
    end

    steady_run = 1'b0;
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
